// ----- rtl/imh_pkg.sv -----
package imh_pkg;

   localparam int NODE_PORT_W = 11;
   localparam int KEY_W       = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;

   localparam logic [KEY_W-1:0] KEY_INF = '1;

   typedef enum logic [OP_W-1:0] {
      OP_INIT    = 2'd0,
      OP_INSERT  = 2'd1,
      OP_EXTRACT = 2'd2,
      OP_UPDATE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_NOTIN = 2'd3
   } status_type;

   typedef struct packed {
      logic heap_we;
      logic pos_we;
   } mem_ctl_type;

endpackage

// ----- rtl/imh_store.sv -----
module imh_store #(
   parameter int MAX_NODES = 1024
) (
   input  logic                                          clock,
   input  imh_pkg::mem_ctl_type                          ctl,
   input  logic [$clog2(MAX_NODES+1)-1:0]                heap_ra0,
   input  logic [$clog2(MAX_NODES+1)-1:0]                heap_ra1,
   input  logic [$clog2(MAX_NODES+1)-1:0]                heap_wa,
   input  logic [$clog2(MAX_NODES+1)+imh_pkg::KEY_W-1:0] heap_wd,
   output logic [$clog2(MAX_NODES+1)+imh_pkg::KEY_W-1:0] heap_rd0,
   output logic [$clog2(MAX_NODES+1)+imh_pkg::KEY_W-1:0] heap_rd1,
   input  logic [$clog2(MAX_NODES)-1:0]                  pos_ra,
   input  logic [$clog2(MAX_NODES)-1:0]                  pos_wa,
   input  logic [$clog2(MAX_NODES+1)-1:0]                pos_wd,
   output logic [$clog2(MAX_NODES+1)-1:0]                pos_rd
);
   import imh_pkg::*;

   localparam int NW = $clog2(MAX_NODES+1);

   logic [NW+KEY_W-1:0] heap_mem [0:MAX_NODES];
   logic [NW-1:0]       pos_mem  [0:MAX_NODES-1];

   always_ff @(posedge clock) begin
      if (ctl.heap_we) begin
         heap_mem[heap_wa] <= heap_wd;
      end
      heap_rd0 <= heap_mem[heap_ra0];
      heap_rd1 <= heap_mem[heap_ra1];
   end

   always_ff @(posedge clock) begin
      if (ctl.pos_we) begin
         pos_mem[pos_wa] <= pos_wd;
      end
      pos_rd <= pos_mem[pos_ra];
   end

endmodule

// ----- rtl/imh_ctrl.sv -----
module imh_ctrl #(
   parameter int MAX_NODES = 1024
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  imh_pkg::op_type                               req_op,
   input  logic [imh_pkg::NODE_PORT_W-1:0]               req_node,
   input  logic [imh_pkg::KEY_W-1:0]                     req_key,
   input  logic [imh_pkg::NODE_PORT_W-1:0]               node_count,
   input  logic                                          out_free,
   output logic                                          ready,
   output logic                                          done,
   output logic [imh_pkg::NODE_PORT_W-1:0]               res_node,
   output logic [imh_pkg::KEY_W-1:0]                     res_key,
   output logic [imh_pkg::NODE_PORT_W-1:0]               res_size,
   output logic                                          res_empty,
   output imh_pkg::status_type                           res_status,
   output imh_pkg::mem_ctl_type                          ctl,
   output logic [$clog2(MAX_NODES+1)-1:0]                heap_ra0,
   output logic [$clog2(MAX_NODES+1)-1:0]                heap_ra1,
   output logic [$clog2(MAX_NODES+1)-1:0]                heap_wa,
   output logic [$clog2(MAX_NODES+1)+imh_pkg::KEY_W-1:0] heap_wd,
   input  logic [$clog2(MAX_NODES+1)+imh_pkg::KEY_W-1:0] heap_rd0,
   input  logic [$clog2(MAX_NODES+1)+imh_pkg::KEY_W-1:0] heap_rd1,
   output logic [$clog2(MAX_NODES)-1:0]                  pos_ra,
   output logic [$clog2(MAX_NODES)-1:0]                  pos_wa,
   output logic [$clog2(MAX_NODES+1)-1:0]                pos_wd,
   input  logic [$clog2(MAX_NODES+1)-1:0]                pos_rd
);
   import imh_pkg::*;

   localparam int NW = $clog2(MAX_NODES+1);
   localparam int PW = $clog2(MAX_NODES);
   localparam logic [NW-1:0] MAX_N = NW'(MAX_NODES);
   localparam logic [NW-1:0] ONE   = NW'(1);

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_INIT = 10'b0000000010,
      S_CHK1 = 10'b0000000100,
      S_CHK2 = 10'b0000001000,
      S_UP   = 10'b0000010000,
      S_UPC  = 10'b0000100000,
      S_EX   = 10'b0001000000,
      S_DN   = 10'b0010000000,
      S_DNC  = 10'b0100000000,
      S_DONE = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [NW-1:0]       nd_ff, nd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [NW-1:0]       count_ff, count_in;
   logic [NW-1:0]       pos_ff, pos_in;
   logic [NW+KEY_W-1:0] mov_ff, mov_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [NW-1:0]       idx_ff, idx_in;
   logic [NW-1:0]       onode_ff, onode_in;
   logic [KEY_W-1:0]    okey_ff, okey_in;
   status_type          status_ff, status_in;

   logic [NW-1:0]       req_nd;
   logic                req_bad;
   logic [NW-1:0]       init_n;
   logic [NW-1:0]       mov_node;
   logic [KEY_W-1:0]    mov_key;
   logic [NW:0]         two;
   logic [NW:0]         cnt_x;
   logic                pick_right;
   logic [NW+KEY_W-1:0] child;

   assign req_nd   = NW'(req_node);
   assign req_bad  = (req_node == '0) || (32'(req_node) > 32'(MAX_NODES));
   assign init_n   = (32'(node_count) > 32'(MAX_NODES)) ? MAX_N : NW'(node_count);
   assign mov_node = mov_ff[NW+KEY_W-1:KEY_W];
   assign mov_key  = mov_ff[KEY_W-1:0];
   assign two      = {pos_ff, 1'b0};
   assign cnt_x    = {1'b0, count_ff};
   assign pick_right = (two < cnt_x) && (heap_rd0[KEY_W-1:0] > heap_rd1[KEY_W-1:0]);
   assign child    = pick_right ? heap_rd1 : heap_rd0;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      nd_in     = nd_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      mov_in    = mov_ff;
      n_in      = n_ff;
      idx_in    = idx_ff;
      onode_in  = onode_ff;
      okey_in   = okey_ff;
      status_in = status_ff;
      ctl       = '0;
      heap_ra0  = pos_ff;
      heap_ra1  = pos_ff;
      heap_wa   = pos_ff;
      heap_wd   = mov_ff;
      pos_ra    = PW'(nd_ff - ONE);
      pos_wa    = PW'(mov_node - ONE);
      pos_wd    = pos_ff;
      case (state_ff)
         S_IDLE: begin
            pos_ra = PW'(req_nd - ONE);
            if (start) begin
               op_in     = req_op;
               nd_in     = req_nd;
               key_in    = req_key;
               onode_in  = '0;
               okey_in   = '0;
               status_in = ST_OK;
               case (req_op)
                  OP_INIT: begin
                     if (init_n == '0) begin
                        count_in = '0;
                        state_in = S_DONE;
                     end else begin
                        idx_in   = ONE;
                        n_in     = init_n;
                        state_in = S_INIT;
                     end
                  end
                  OP_INSERT: begin
                     if (count_ff >= MAX_N) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else if (req_bad) begin
                        status_in = ST_NOTIN;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_CHK1;
                     end
                  end
                  OP_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        heap_ra0 = ONE;
                        heap_ra1 = count_ff;
                        state_in = S_EX;
                     end
                  end
                  OP_UPDATE: begin
                     if (req_bad) begin
                        status_in = ST_NOTIN;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_CHK1;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_INIT: begin
            ctl.heap_we = 1'b1;
            ctl.pos_we  = 1'b1;
            heap_wa     = idx_ff;
            heap_wd     = {idx_ff, KEY_INF};
            pos_wa      = PW'(idx_ff - ONE);
            pos_wd      = idx_ff;
            idx_in      = idx_ff + ONE;
            if (idx_ff == n_ff) begin
               count_in = n_ff;
               state_in = S_DONE;
            end
         end
         S_CHK1: begin
            if ((pos_rd == '0) || (pos_rd > count_ff)) begin
               if (op_ff == OP_INSERT) begin
                  count_in = count_ff + ONE;
                  pos_in   = count_ff + ONE;
                  mov_in   = {nd_ff, key_ff};
                  state_in = S_UP;
               end else begin
                  status_in = ST_NOTIN;
                  state_in  = S_DONE;
               end
            end else begin
               heap_ra0 = pos_rd;
               pos_in   = pos_rd;
               state_in = S_CHK2;
            end
         end
         S_CHK2: begin
            if (heap_rd0[NW+KEY_W-1:KEY_W] == nd_ff) begin
               if (op_ff == OP_INSERT) begin
                  status_in = ST_NOTIN;
                  state_in  = S_DONE;
               end else begin
                  mov_in   = {nd_ff, key_ff};
                  state_in = S_UP;
               end
            end else begin
               if (op_ff == OP_INSERT) begin
                  count_in = count_ff + ONE;
                  pos_in   = count_ff + ONE;
                  mov_in   = {nd_ff, key_ff};
                  state_in = S_UP;
               end else begin
                  status_in = ST_NOTIN;
                  state_in  = S_DONE;
               end
            end
         end
         S_UP: begin
            if (pos_ff == ONE) begin
               ctl.heap_we = 1'b1;
               ctl.pos_we  = 1'b1;
               state_in    = S_DONE;
            end else begin
               heap_ra0 = pos_ff >> 1;
               state_in = S_UPC;
            end
         end
         S_UPC: begin
            ctl.heap_we = 1'b1;
            ctl.pos_we  = 1'b1;
            if (heap_rd0[KEY_W-1:0] > mov_key) begin
               heap_wd  = heap_rd0;
               pos_wa   = PW'(heap_rd0[NW+KEY_W-1:KEY_W] - ONE);
               pos_in   = pos_ff >> 1;
               state_in = S_UP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_EX: begin
            onode_in   = heap_rd0[NW+KEY_W-1:KEY_W];
            okey_in    = heap_rd0[KEY_W-1:0];
            ctl.pos_we = 1'b1;
            pos_wa     = PW'(heap_rd0[NW+KEY_W-1:KEY_W] - ONE);
            pos_wd     = count_ff;
            count_in   = count_ff - ONE;
            if (count_ff == ONE) begin
               state_in = S_DONE;
            end else begin
               mov_in   = heap_rd1;
               pos_in   = ONE;
               state_in = S_DN;
            end
         end
         S_DN: begin
            if (two > cnt_x) begin
               ctl.heap_we = 1'b1;
               ctl.pos_we  = 1'b1;
               state_in    = S_DONE;
            end else begin
               heap_ra0 = NW'(two);
               heap_ra1 = (two < cnt_x) ? NW'(two + 1'b1) : NW'(two);
               state_in = S_DNC;
            end
         end
         S_DNC: begin
            ctl.heap_we = 1'b1;
            ctl.pos_we  = 1'b1;
            if (mov_key <= child[KEY_W-1:0]) begin
               state_in = S_DONE;
            end else begin
               heap_wd  = child;
               pos_wa   = PW'(child[NW+KEY_W-1:KEY_W] - ONE);
               pos_in   = pick_right ? NW'(two + 1'b1) : NW'(two);
               state_in = S_DN;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      nd_ff     <= nd_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      mov_ff    <= mov_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      onode_ff  <= onode_in;
      okey_ff   <= okey_in;
      status_ff <= status_in;
   end

   assign ready      = (state_ff == S_IDLE);
   assign done       = (state_ff == S_DONE);
   assign res_node   = NODE_PORT_W'(onode_ff);
   assign res_key    = okey_ff;
   assign res_size   = NODE_PORT_W'(count_ff);
   assign res_empty  = (count_ff == '0);
   assign res_status = status_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_N)
      else $error("Heap count exceeds its capacity.");

   a_heap_write_slot: assert property (@(posedge clock) disable iff (reset)
      (ctl.heap_we && state_ff != S_INIT) |-> (heap_wa != '0 && heap_wa <= count_ff))
      else $error("Heap write lies outside the occupied slots.");

   a_up_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP || state_ff == S_UPC) |-> (pos_ff != '0))
      else $error("Sift-up reached slot zero.");

   a_done_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (state_ff == S_IDLE))
      else $error("Finished transaction did not release the controller.");

endmodule

// ----- rtl/indexed_min_heap_decrease_key.sv -----
// Init fills node_count slots (capped at MAX_NODES) with infinite keys; insert and update check
// the slot memory and then sift the key up one level at a time, and extract moves the last entry
// to the root and sifts it down level by level. One transaction at a time: the next request is
// taken once the controller has returned to idle after its result was registered into the output.
// A stalled result holds off the input.
// Reset clears the heap count, controller and output valid and sets node_count to 1024 only.
module indexed_min_heap_decrease_key #(
   parameter int MAX_NODES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // node_id, key_in
   input  logic [1:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // out_node, out_key, heap_size, is_empty
   output logic [1:0]  rsp_tuser,  // status
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);
   import imh_pkg::*;

   localparam int NW = $clog2(MAX_NODES+1);
   localparam int PW = $clog2(MAX_NODES);

   logic [NODE_PORT_W-1:0] node_count_ff;
   logic                   rsp_valid_ff;
   logic [55:0]            rsp_data_ff;
   logic [1:0]             rsp_user_ff;

   logic                   start;
   logic                   done;
   logic                   out_free;
   logic [NODE_PORT_W-1:0] res_node;
   logic [KEY_W-1:0]       res_key;
   logic [NODE_PORT_W-1:0] res_size;
   logic                   res_empty;
   status_type             res_status;
   mem_ctl_type            ctl;
   logic [NW-1:0]          heap_ra0, heap_ra1, heap_wa;
   logic [NW+KEY_W-1:0]    heap_wd, heap_rd0, heap_rd1;
   logic [PW-1:0]          pos_ra, pos_wa;
   logic [NW-1:0]          pos_wd, pos_rd;

   assign start    = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   imh_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (op_type'(req_tuser)),
      .req_node   (req_tdata[10:0]),
      .req_key    (req_tdata[42:11]),
      .node_count (node_count_ff),
      .out_free   (out_free),
      .ready      (req_tready),
      .done       (done),
      .res_node   (res_node),
      .res_key    (res_key),
      .res_size   (res_size),
      .res_empty  (res_empty),
      .res_status (res_status),
      .ctl        (ctl),
      .heap_ra0   (heap_ra0),
      .heap_ra1   (heap_ra1),
      .heap_wa    (heap_wa),
      .heap_wd    (heap_wd),
      .heap_rd0   (heap_rd0),
      .heap_rd1   (heap_rd1),
      .pos_ra     (pos_ra),
      .pos_wa     (pos_wa),
      .pos_wd     (pos_wd),
      .pos_rd     (pos_rd)
   );

   imh_store #(.MAX_NODES(MAX_NODES)) u_store (
      .clock    (clock),
      .ctl      (ctl),
      .heap_ra0 (heap_ra0),
      .heap_ra1 (heap_ra1),
      .heap_wa  (heap_wa),
      .heap_wd  (heap_wd),
      .heap_rd0 (heap_rd0),
      .heap_rd1 (heap_rd1),
      .pos_ra   (pos_ra),
      .pos_wa   (pos_wa),
      .pos_wd   (pos_wd),
      .pos_rd   (pos_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 11'd1024;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
         if (done && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done && out_free) begin
         rsp_data_ff <= {1'b0, res_empty, res_size, res_key, res_node};
         rsp_user_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
